// ===== sv/kms_pkg.sv =====
// shared types and constants of the key matrix scanner
`timescale 1ns / 1ps
`default_nettype none
package kms_pkg;

	localparam int ROWS = 5;
	localparam int COLUMNS = 6;

	localparam int ROW_W = 3;
	localparam int COL_W = 3;
	localparam int LVL_W = 5;
	localparam int CODE_W = 8;
	localparam int KIND_W = 2;
	localparam int ACT_W = 2;
	localparam int NSPECIAL = 4;
	localparam int CFG_IDX_W = 2;

	localparam int CIDX_W = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int KADDR_W = (ROWS * COLUMNS > 1) ? $clog2(ROWS * COLUMNS) : 1;

	localparam int FIFO_DEPTH = 4;
	localparam int FPTR_W = $clog2(FIFO_DEPTH);
	localparam int FCNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic ACTION_SCAN = 1'b0;
	localparam logic ACTION_LOAD = 1'b1;

	localparam logic [KIND_W-1:0] KIND_EVENT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SPECIAL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DONE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_PAIRING = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_START_ADVERTISING = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_SCANNING = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ACCEPT_CENTRAL = 2'd3;

	localparam logic [CODE_W-1:0] SPECIAL_RESET [NSPECIAL] = '{8'd168, 8'd167, 8'd165, 8'd166};

	typedef struct packed {
		logic action;
		logic [LVL_W-1:0] row_levels;
		logic [ROW_W-1:0] entry_row;
		logic [COL_W-1:0] entry_column;
		logic [CODE_W-1:0] entry_code;
	} item_t;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [ROW_W-1:0] key_row;
		logic [COL_W-1:0] key_column;
		logic [CODE_W-1:0] key_code;
		logic pressed;
		logic [ACT_W-1:0] special_action;
		logic notify;
		logic [COL_W-1:0] next_column;
		logic last;
	} result_t;

	typedef struct packed {
		logic [FCNT_W-1:0] count;
	} fifo_status_t;

endpackage
`default_nettype wire

// ===== sv/key_matrix_scanner.sv =====
// key matrix scanner top level: pressed-bit and keymap memories, row sequencer, result queue
//
// Usage:
//   item channel (item_valid/item_ready/item): a scan item carries the row levels sampled on
//   the column currently driven; a load item writes one keymap entry (out of range is dropped).
//   result channel (result_valid/result_ready/result): per scan item, one result for each
//   changed key from row 0 upward (a released special key gives none), then a done result
//   with last set, the next column to drive and the notify flag. Loads give no result.
//   cfg_we/cfg_index/cfg_data write the four special codes; write only while the block is idle.
// A scan item is registered at accept, its results in the classify stage and then the queue.
// Sequencing: a scan item takes a sequencer step per changed key and one for the done token,
//   a load one idle turn; one keymap read per cycle while the queue has room sets the rate.
// Reset clears the pressed bits (per-column valid flags), the drive column, the queue, and
//   loads the default special codes; the keymap holds garbage until loaded.
// Stall: results wait in a 4-entry queue; the sequencer pauses when the queue has no room,
//   and the item channel keeps taking one item ahead while the sequencer is busy.
`timescale 1ns / 1ps
`default_nettype none
module key_matrix_scanner
	import kms_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	output logic item_ready,
	input wire item_t item,
	output logic result_valid,
	input wire logic result_ready,
	output result_t result,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CODE_W-1:0] cfg_data
);

	// configuration
	logic [CODE_W-1:0] special_q [NSPECIAL];

	// memories
	logic [ROWS-1:0] pressed_mem [COLUMNS];
	logic [COLUMNS-1:0] pvalid_q;
	logic [CODE_W-1:0] keymap_mem [ROWS*COLUMNS];

	// accept stage
	logic [COL_W-1:0] drive_q;
	logic item_acc;
	logic s1_valid_q;
	item_t item_s1;
	logic [COL_W-1:0] col_s1;
	logic [ROWS-1:0] prd_s1;
	logic pvld_s1;
	logic pfwd_s1;
	logic [ROWS-1:0] pfwd_data_s1;
	logic [ROWS-1:0] old_bits;
	logic [ROWS-1:0] levels_s1;

	// row sequencer
	logic busy_q;
	logic [ROWS-1:0] mask_q;
	logic [ROWS-1:0] levels_q;
	logic [COL_W-1:0] col_q;
	logic [ROWS-1:0] cur_mask;
	logic [ROWS-1:0] cur_levels;
	logic [COL_W-1:0] cur_col;
	logic [COL_W-1:0] cur_next;
	logic [ROWS-1:0] low_bit;
	logic [ROW_W-1:0] row_sel;
	logic s1_scan;
	logic s1_load;
	logic credit_ok;
	logic step;
	logic take_scan;
	logic take_load;
	logic load_in_range;
	logic [KADDR_W-1:0] k_raddr;
	logic [KADDR_W-1:0] k_waddr;
	logic [CIDX_W-1:0] p_addr_rd;
	logic [CIDX_W-1:0] p_addr_wr;

	// classify stage
	logic s3_valid_q;
	logic done_s3;
	logic [ROW_W-1:0] row_s3;
	logic [COL_W-1:0] col_s3;
	logic now_s3;
	logic [COL_W-1:0] next_s3;
	logic [CODE_W-1:0] code_s3;
	logic changed_q;
	logic hit;
	logic [ACT_W-1:0] act;
	logic push;
	result_t push_data;
	fifo_status_t fifo_status;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NSPECIAL; k++) begin
				special_q[k] <= SPECIAL_RESET[k];
			end
		end else if (cfg_we) begin
			special_q[cfg_index] <= cfg_data;
		end
	end

	// accept stage control
	assign s1_scan = s1_valid_q && (item_s1.action == ACTION_SCAN);
	assign s1_load = s1_valid_q && (item_s1.action == ACTION_LOAD);
	assign credit_ok = ({1'b0, fifo_status.count} + (FCNT_W+1)'(s3_valid_q))
		< (FCNT_W+1)'(FIFO_DEPTH);
	assign take_scan = !busy_q && s1_scan && credit_ok;
	assign take_load = !busy_q && s1_load;
	assign item_ready = !s1_valid_q || take_scan || take_load;
	assign item_acc = item_valid && item_ready;

	assign p_addr_rd = drive_q[CIDX_W-1:0];
	assign p_addr_wr = col_s1[CIDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
			drive_q <= '0;
			pvalid_q <= '0;
		end else begin
			if (item_acc) begin
				s1_valid_q <= 1'b1;
			end else if (take_scan || take_load) begin
				s1_valid_q <= 1'b0;
			end
			if (item_acc && item.action == ACTION_SCAN) begin
				drive_q <= (drive_q == COL_W'(COLUMNS - 1)) ? '0 : drive_q + COL_W'(1);
			end
			if (take_scan) begin
				pvalid_q[p_addr_wr] <= 1'b1;
			end
		end
	end

	// pressed-bit memory: written back when the sequencer takes the item
	always_ff @(posedge clk) begin
		if (take_scan) begin
			pressed_mem[p_addr_wr] <= levels_s1;
		end
		if (item_acc) begin
			item_s1 <= item;
			col_s1 <= drive_q;
			prd_s1 <= pressed_mem[p_addr_rd];
			pvld_s1 <= pvalid_q[p_addr_rd];
			// same column written this cycle: take the new bits
			pfwd_s1 <= take_scan && (p_addr_wr == p_addr_rd);
			pfwd_data_s1 <= levels_s1;
		end
	end

	assign levels_s1 = item_s1.row_levels[ROWS-1:0];
	assign old_bits = pfwd_s1 ? pfwd_data_s1 : (pvld_s1 ? prd_s1 : '0);

	// row sequencer: one changed row per cycle while the queue has room, then the done token
	assign cur_mask = busy_q ? mask_q : (old_bits ^ levels_s1);
	assign cur_levels = busy_q ? levels_q : levels_s1;
	assign cur_col = busy_q ? col_q : col_s1;
	assign cur_next = (cur_col == COL_W'(COLUMNS - 1)) ? '0 : cur_col + COL_W'(1);
	assign step = (busy_q || s1_scan) && credit_ok;
	assign low_bit = cur_mask & (~cur_mask + ROWS'(1));

	always_comb begin
		row_sel = '0;
		for (int r = ROWS - 1; r >= 0; r--) begin
			if (cur_mask[r]) begin
				row_sel = ROW_W'(r);
			end
		end
	end

	assign k_raddr = KADDR_W'(KADDR_W'(row_sel) * KADDR_W'(COLUMNS) + KADDR_W'(cur_col));
	assign k_waddr = KADDR_W'(KADDR_W'(item_s1.entry_row) * KADDR_W'(COLUMNS)
		+ KADDR_W'(item_s1.entry_column));
	assign load_in_range = ({1'b0, item_s1.entry_row} < (ROW_W+1)'(ROWS))
		&& ({1'b0, item_s1.entry_column} < (COL_W+1)'(COLUMNS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			s3_valid_q <= 1'b0;
		end else begin
			s3_valid_q <= step;
			if (step) begin
				busy_q <= (cur_mask != '0);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			mask_q <= cur_mask & ~low_bit;
			levels_q <= cur_levels;
			col_q <= cur_col;
			done_s3 <= (cur_mask == '0);
			row_s3 <= row_sel;
			col_s3 <= cur_col;
			now_s3 <= cur_levels[row_sel];
			next_s3 <= cur_next;
		end
	end

	// keymap memory: loads take their turn in the sequencer, so reads keep item order
	always_ff @(posedge clk) begin
		if (take_load && load_in_range) begin
			keymap_mem[k_waddr] <= item_s1.entry_code;
		end
		if (step) begin
			code_s3 <= keymap_mem[k_raddr];
		end
	end

	// classify stage; lowest special number wins on equal codes
	always_comb begin
		hit = 1'b0;
		act = '0;
		for (int k = NSPECIAL - 1; k >= 0; k--) begin
			if (special_q[k] == code_s3) begin
				hit = 1'b1;
				act = ACT_W'(k);
			end
		end
	end

	assign push = s3_valid_q && (done_s3 || !hit || now_s3);

	always_comb begin
		push_data = '0;
		if (done_s3) begin
			push_data.kind = KIND_DONE;
			push_data.notify = changed_q;
			push_data.next_column = next_s3;
			push_data.last = 1'b1;
		end else begin
			push_data.key_row = row_s3;
			push_data.key_column = col_s3;
			push_data.key_code = code_s3;
			if (hit) begin
				push_data.kind = KIND_SPECIAL;
				push_data.pressed = 1'b1;
				push_data.special_action = act;
			end else begin
				push_data.kind = KIND_EVENT;
				push_data.pressed = now_s3;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			changed_q <= 1'b0;
		end else if (s3_valid_q) begin
			if (done_s3) begin
				changed_q <= 1'b0;
			end else if (!hit) begin
				changed_q <= 1'b1;
			end
		end
	end

	kms_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.status(fifo_status)
	);

endmodule
`default_nettype wire

// ===== sv/kms_fifo.sv =====
// result queue between the classify stage and the output channel
`timescale 1ns / 1ps
`default_nettype none
module kms_fifo
	import kms_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic push,
	input wire result_t push_data,
	output logic result_valid,
	input wire logic result_ready,
	output result_t result,
	output fifo_status_t status
);

	result_t entry_q [FIFO_DEPTH];
	logic [FPTR_W-1:0] wr_ptr_q;
	logic [FPTR_W-1:0] rd_ptr_q;
	logic [FCNT_W-1:0] count_q;
	logic pop;

	assign result_valid = (count_q != '0);
	assign result = entry_q[rd_ptr_q];
	assign pop = result_valid && result_ready;
	assign status.count = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + FPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + FPTR_W'(1);
			end
			case ({push, pop})
				2'b10: count_q <= count_q + FCNT_W'(1);
				2'b01: count_q <= count_q - FCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== sv/kms_checker.sv =====
// port-level checks of the key matrix scanner result channel
`timescale 1ns / 1ps
`default_nettype none
module kms_checker
	import kms_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic result_valid,
	input wire logic result_ready,
	input wire result_t result
);

	// a waiting item holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("result changed while stalled");

	// only the done item closes a scan
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.last == (result.kind == KIND_DONE)))
		else $error("last flag does not match done kind");

	// specials come on press only
	a_special: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_SPECIAL |-> result.pressed)
		else $error("special action on release");

	// next column stays in the matrix
	a_next: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_DONE
		|-> {1'b0, result.next_column} < (COL_W+1)'(COLUMNS))
		else $error("next column out of range");

endmodule

bind key_matrix_scanner kms_checker u_kms_checker (.*);
`default_nettype wire

// ===== test/kms_scan_checker.sv =====
// result checker for the key matrix scanner: predicts results of accepted items and compares
`timescale 1ns / 1ps
module kms_scan_checker
	import kms_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic item_valid,
	input wire logic item_ready,
	input wire item_t item,
	input wire logic result_valid,
	input wire logic result_ready,
	input wire result_t result,
	input wire logic cfg_we,
	input wire logic [CFG_IDX_W-1:0] cfg_index,
	input wire logic [CODE_W-1:0] cfg_data,
	output int errors,
	output int outstanding
);

	logic [CODE_W-1:0] special_code [NSPECIAL];
	logic [ROWS-1:0] key_state [COLUMNS];
	logic [CODE_W-1:0] code_map [ROWS][COLUMNS];
	int column;
	result_t predicted_results [$];

	task automatic predict_scan(input logic [ROWS-1:0] levels);
		logic [ROWS-1:0] held;
		logic [CODE_W-1:0] code;
		int act_no;
		bit ordinary_change;
		result_t r;
		held = key_state[column];
		ordinary_change = 1'b0;
		for (int row = 0; row < ROWS; row++) begin
			if (levels[row] == held[row])
				continue;
			code = code_map[row][column];
			// scan downward so the lowest matching action number is kept
			act_no = -1;
			for (int k = NSPECIAL - 1; k >= 0; k--)
				if (special_code[k] == code)
					act_no = k;
			r = '0;
			r.key_row = row;
			r.key_column = column;
			r.key_code = code;
			if (act_no >= 0) begin
				// a released special key is silent
				if (levels[row]) begin
					r.kind = KIND_SPECIAL;
					r.pressed = 1'b1;
					r.special_action = act_no;
					predicted_results.push_back(r);
				end
			end else begin
				r.kind = KIND_EVENT;
				r.pressed = levels[row];
				predicted_results.push_back(r);
				ordinary_change = 1'b1;
			end
		end
		key_state[column] = levels;
		column = (column + 1 < COLUMNS) ? column + 1 : 0;
		r = '0;
		r.kind = KIND_DONE;
		r.notify = ordinary_change;
		r.next_column = column;
		r.last = 1'b1;
		predicted_results.push_back(r);
	endtask

	task automatic compare_field(input string name, input logic [CODE_W-1:0] want,
			input logic [CODE_W-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t: result field %s expected %0d actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t want;
		if (!arst_n) begin
			special_code = SPECIAL_RESET;
			for (int c = 0; c < COLUMNS; c++)
				key_state[c] = '0;
			column = 0;
			predicted_results.delete();
			errors = 0;
			outstanding <= 0;
		end else begin
			if (cfg_we)
				special_code[cfg_index] = cfg_data;
			if (item_valid && item_ready) begin
				if (item.action == ACTION_LOAD) begin
					if (item.entry_row < ROWS && item.entry_column < COLUMNS)
						code_map[item.entry_row][item.entry_column] = item.entry_code;
				end else begin
					predict_scan(item.row_levels);
				end
			end
			if (result_valid && result_ready) begin
				if (predicted_results.size() == 0) begin
					errors++;
					$display("%0t: result expected none actual %p", $time, result);
				end else begin
					want = predicted_results.pop_front();
					compare_field("kind", want.kind, result.kind);
					compare_field("key_row", want.key_row, result.key_row);
					compare_field("key_column", want.key_column, result.key_column);
					compare_field("key_code", want.key_code, result.key_code);
					compare_field("pressed", want.pressed, result.pressed);
					compare_field("special_action", want.special_action, result.special_action);
					compare_field("notify", want.notify, result.notify);
					compare_field("next_column", want.next_column, result.next_column);
					compare_field("last", want.last, result.last);
				end
			end
			outstanding <= predicted_results.size();
		end
	end

endmodule

// ===== test/tb_key_matrix_scanner.sv =====
// testbench top for the key matrix scanner: stimulus, special code settings and verdict
`timescale 1ns / 1ps
module tb_key_matrix_scanner;
	import kms_pkg::*;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_CYCLES = 200;
	localparam int SEGMENT_ITEMS = 92;

	logic clk = 1'b0;
	logic arst_n;
	logic item_valid;
	logic item_ready;
	item_t item;
	logic result_valid;
	logic result_ready;
	result_t result;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CODE_W-1:0] cfg_data;
	int errors;
	int outstanding;
	int idle_cycles = 0;

	// sender view of the matrix, keeps scans away from keymap entries never loaded
	logic [ROWS-1:0] key_levels [COLUMNS];
	logic [ROWS-1:0] loaded [COLUMNS];
	int scan_column;
	logic [CODE_W-1:0] codes [NSPECIAL];
	bit idling;
	bit hold_req;

	always #2 clk = ~clk;

	key_matrix_scanner uut (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	kms_scan_checker scan_check (
		.clk(clk),
		.arst_n(arst_n),
		.item_valid(item_valid),
		.item_ready(item_ready),
		.item(item),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result(result),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.errors(errors),
		.outstanding(outstanding)
	);

	task automatic offer(input item_t it);
		item <= it;
		item_valid <= 1'b1;
		do @(posedge clk); while (!item_ready);
	endtask

	task automatic sender_gap();
		if (idling && $urandom_range(0, 99) < 15) begin
			item_valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
	endtask

	task automatic load_entry(input logic [ROW_W-1:0] r, input logic [COL_W-1:0] c,
			input logic [CODE_W-1:0] code);
		item_t it;
		it.action = ACTION_LOAD;
		it.row_levels = $urandom;
		it.entry_row = r;
		it.entry_column = c;
		it.entry_code = code;
		sender_gap();
		offer(it);
		if (r < ROWS && c < COLUMNS)
			loaded[c][r] = 1'b1;
	endtask

	task automatic scan(input logic [ROWS-1:0] raw);
		item_t it;
		it.action = ACTION_SCAN;
		it.row_levels = (raw & loaded[scan_column])
			| (key_levels[scan_column] & ~loaded[scan_column]);
		it.entry_row = $urandom;
		it.entry_column = $urandom;
		it.entry_code = $urandom;
		sender_gap();
		offer(it);
		key_levels[scan_column] = it.row_levels;
		scan_column = (scan_column + 1) % COLUMNS;
	endtask

	function automatic logic [CODE_W-1:0] pick_code();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return codes[$urandom_range(0, NSPECIAL - 1)];
			4: return 8'h00;
			5: return 8'hFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [ROWS-1:0] pick_levels();
		case ($urandom_range(0, 3))
			0: return key_levels[scan_column];
			1: return key_levels[scan_column] ^ (1 << $urandom_range(0, ROWS - 1));
			default: return $urandom;
		endcase
	endfunction

	task automatic run_segment(input int n, input int load_pct);
		int sent;
		sent = 0;
		while (sent < n) begin
			if ($urandom_range(0, 99) < load_pct) begin
				if ($urandom_range(0, 7) == 0) begin
					// dropped load, row or column past the matrix
					if ($urandom_range(0, 1))
						load_entry($urandom_range(ROWS, 7), $urandom_range(0, 7), $urandom);
					else
						load_entry($urandom_range(0, 7), $urandom_range(COLUMNS, 7), $urandom);
				end else begin
					load_entry($urandom_range(0, ROWS - 1), $urandom_range(0, COLUMNS - 1),
						pick_code());
					sent++;
				end
			end else begin
				scan(pick_levels());
				sent++;
			end
		end
	endtask

	// sender stops until every result is back, then the scanner is given time to finish
	task automatic drain();
		item_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_codes(input logic [CODE_W-1:0] a, input logic [CODE_W-1:0] b,
			input logic [CODE_W-1:0] c, input logic [CODE_W-1:0] d);
		logic [CFG_IDX_W-1:0] index_of [NSPECIAL];
		logic [CODE_W-1:0] value_of [NSPECIAL];
		index_of = '{REG_ACCEPT_PAIRING, REG_START_ADVERTISING, REG_START_SCANNING,
			REG_ACCEPT_CENTRAL};
		value_of = '{a, b, c, d};
		for (int i = 0; i < NSPECIAL; i++) begin
			cfg_index <= index_of[i];
			cfg_data <= value_of[i];
			cfg_we <= 1'b1;
			codes[i] = value_of[i];
			@(posedge clk);
		end
		cfg_we <= 1'b0;
	endtask

	// result side: random stalls plus one long hold-off while the sender keeps going
	initial begin
		bit hold_seen;
		hold_seen = 1'b0;
		result_ready <= 1'b0;
		do @(posedge clk); while (!arst_n);
		forever begin
			if (hold_req && !hold_seen) begin
				hold_seen = 1'b1;
				result_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (idling && $urandom_range(0, 99) < 15) begin
				result_ready <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
			end else begin
				result_ready <= 1'b1;
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if ((item_valid && item_ready) || (result_valid && result_ready))
			idle_cycles = 0;
		else
			idle_cycles = idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("key_matrix_scanner verification failed");
			$finish;
		end
	end

	initial begin
		arst_n <= 1'b0;
		item_valid <= 1'b0;
		item <= '0;
		cfg_we <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		idling = 1'b1;
		hold_req = 1'b0;
		scan_column = 0;
		for (int c = 0; c < COLUMNS; c++) begin
			key_levels[c] = '0;
			loaded[c] = '0;
		end
		codes = SPECIAL_RESET;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// loads outside the matrix are dropped
		load_entry(7, 7, 8'hFF);
		load_entry(ROWS, 0, 8'h3C);
		load_entry(0, COLUMNS, 8'hC3);
		// column 0 mixes ordinary extremes with specials, column 1 mixes other ordinary codes with specials
		load_entry(0, 0, 8'h00);
		load_entry(1, 0, 8'hFF);
		load_entry(2, 0, codes[0]);
		load_entry(3, 0, codes[1]);
		load_entry(4, 0, codes[2]);
		load_entry(0, 1, codes[3]);
		load_entry(1, 1, 8'h5A);
		load_entry(2, 1, 8'hA5);
		load_entry(3, 1, codes[0]);
		load_entry(4, 1, 8'h01);
		load_entry(ROWS - 1, COLUMNS - 1, 8'hFF);
		// press every loaded key on every column, wrap, then release columns 0 and 1
		repeat (COLUMNS) scan('1);
		scan('0);
		scan('0);
		drain();

		hold_req = 1'b1;
		run_segment(SEGMENT_ITEMS, 35);
		drain();

		// equal codes on advertise and central, extremes on pairing, advertise and central
		set_codes(8'h00, 8'hFF, 8'h11, 8'hFF);
		idling = 1'b0;
		run_segment(SEGMENT_ITEMS, 20);
		drain();

		idling = 1'b1;
		set_codes(8'h2A, 8'h2A, 8'h2A, 8'h2A);
		run_segment(SEGMENT_ITEMS, 20);
		drain();

		set_codes(8'hFF, 8'h00, 8'h80, 8'h01);
		run_segment(SEGMENT_ITEMS, 20);
		drain();

		set_codes(8'd168, 8'd167, 8'd165, 8'd166);
		idling = 1'b0;
		run_segment(SEGMENT_ITEMS, 20);
		drain();

		if (errors == 0 && outstanding == 0)
			$display("key_matrix_scanner verification clean");
		else
			$display("key_matrix_scanner verification failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/kms_pkg.sv
sv/kms_fifo.sv
sv/key_matrix_scanner.sv
sv/kms_checker.sv
test/kms_scan_checker.sv
test/tb_key_matrix_scanner.sv
